/* hdl/srs_pkg.sv */
package srs_pkg;

   typedef logic [1:0] op_type;

   localparam op_type OP_LOAD  = 2'd0;
   localparam op_type OP_TICK  = 2'd1;
   localparam op_type OP_PIXEL = 2'd2;

   typedef logic [1:0] csr_index_type;

   localparam csr_index_type CSR_ANGLE_STEP      = 2'd0;
   localparam csr_index_type CSR_TRANSPARENT_KEY = 2'd1;
   localparam csr_index_type CSR_BACKGROUND      = 2'd2;

   localparam int unsigned ANGLE_W   = 9;
   localparam int unsigned COLOR_W   = 16;
   localparam int unsigned COORD_W   = 5;
   localparam int unsigned ADDR_W    = 10;
   localparam int unsigned STORE_DEPTH = 1 << ADDR_W;
   localparam int unsigned TRIG_W    = 16;
   localparam int unsigned FRAC_BITS = 14;
   // signed offset from the centre, and its product with a Q1.14 factor
   localparam int unsigned OFFS_W    = 7;
   localparam int unsigned PROD_W    = OFFS_W + TRIG_W;
   localparam int unsigned SUM_W     = PROD_W + 1;
   localparam int unsigned SRC_W     = SUM_W - FRAC_BITS;

   localparam logic [ANGLE_W:0] DEG_90  = 10'd90;
   localparam logic [ANGLE_W:0] DEG_180 = 10'd180;
   localparam logic [ANGLE_W:0] DEG_270 = 10'd270;
   localparam logic [ANGLE_W:0] DEG_360 = 10'd360;
   localparam logic [ANGLE_W:0] DEG_720 = 10'd720;

   localparam logic [ANGLE_W-1:0] ANGLE_STEP_RESET = 9'd3;
   localparam logic [COLOR_W-1:0] KEY_RESET        = 16'hFFFF;
   localparam logic [COLOR_W-1:0] BACKGROUND_RESET = 16'h0000;

   // round(16384 * sin(k degrees)) for k = 0..90
   localparam logic [14:0] SIN_TABLE [0:90] = '{
      15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
      15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
      15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
      15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
      15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
      15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
      15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
      15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
      15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
      15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
      15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
      15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
      15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
   };

   typedef struct packed {
      op_type                op;
      logic [COORD_W-1:0]    dest_x;
      logic [COORD_W-1:0]    dest_y;
      logic [ADDR_W-1:0]     sprite_addr;
      logic [COLOR_W-1:0]    sprite_color;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       covered;
   } rsp_type;

   // rotated products for one item, plus the load payload
   typedef struct packed {
      op_type                   op;
      logic signed [PROD_W-1:0] px_cos;
      logic signed [PROD_W-1:0] py_sin;
      logic signed [PROD_W-1:0] py_cos;
      logic signed [PROD_W-1:0] px_sin;
      logic [ADDR_W-1:0]        sprite_addr;
      logic [COLOR_W-1:0]       sprite_color;
   } prod_type;

   typedef struct packed {
      logic               in_range;
      logic [COLOR_W-1:0] texel;
   } texel_type;

   // Q1.14 sine of an angle in 0..359 degrees
   function automatic logic signed [TRIG_W-1:0] sin_q14(input logic [ANGLE_W-1:0] deg);
      logic [ANGLE_W:0]        d;
      logic [6:0]              idx;
      logic                    neg;
      logic signed [TRIG_W-1:0] mag;
      d = {1'b0, deg};
      if (d < DEG_90) begin
         idx = 7'(d);
         neg = 1'b0;
      end else if (d < DEG_180) begin
         idx = 7'(DEG_180 - d);
         neg = 1'b0;
      end else if (d < DEG_270) begin
         idx = 7'(d - DEG_180);
         neg = 1'b1;
      end else begin
         idx = 7'(DEG_360 - d);
         neg = 1'b1;
      end
      mag = signed'({1'b0, SIN_TABLE[idx]});
      return neg ? -mag : mag;
   endfunction

   function automatic logic signed [TRIG_W-1:0] cos_q14(input logic [ANGLE_W-1:0] deg);
      logic [ANGLE_W:0] d;
      d = {1'b0, deg} + DEG_90;
      if (d >= DEG_360) begin
         d = d - DEG_360;
      end
      return sin_q14(ANGLE_W'(d));
   endfunction

endpackage

/* hdl/sprite_rotation_sampler.sv */
// channel   direction  handshake                 payload
// req       in         req_valid / req_ready     req_payload (op, dest, load word)
// rsp       out        rsp_valid / rsp_ready     rsp_payload (red, green, blue, covered)
// csr       in         csr_we                    csr_index, csr_wdata
//
// One item is taken per cycle while req_ready is high; a pixel result leaves from the colour output register.
// Stages: input register, rotation products, store read, colour output register.
// The sprite store is a single-port memory, read or written once per cycle.
// Reset clears valids, angle and registers; the store itself is not cleared.
// A stall on rsp backs up stage by stage; req_ready falls only when all are full.
module sprite_rotation_sampler #(
   parameter int unsigned SPRITE_SIZE = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  srs_pkg::req_type             req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output srs_pkg::rsp_type             rsp_payload,
   input  logic                         csr_we,
   input  srs_pkg::csr_index_type       csr_index,
   input  logic [srs_pkg::COLOR_W-1:0]  csr_wdata
);
   import srs_pkg::*;

   logic [ANGLE_W-1:0] angle_step_ff;
   logic [COLOR_W-1:0] key_ff;
   logic [COLOR_W-1:0] background_ff;

   logic      prod_valid;
   logic      prod_ready;
   prod_type  prod_data;
   logic      texel_valid;
   logic      texel_ready;
   texel_type texel_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_step_ff <= ANGLE_STEP_RESET;
         key_ff        <= KEY_RESET;
         background_ff <= BACKGROUND_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ANGLE_STEP:      angle_step_ff <= csr_wdata[ANGLE_W-1:0];
            CSR_TRANSPARENT_KEY: key_ff        <= csr_wdata;
            CSR_BACKGROUND:      background_ff <= csr_wdata;
            default: begin
               // no such register: drop the write
            end
         endcase
      end
   end

   srs_rotate #(
      .SPRITE_SIZE(SPRITE_SIZE)
   ) u_rotate (
      .clock      (clock),
      .reset      (reset),
      .angle_step (angle_step_ff),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_data    (req_payload),
      .out_valid  (prod_valid),
      .out_ready  (prod_ready),
      .out_data   (prod_data)
   );

   srs_fetch #(
      .SPRITE_SIZE(SPRITE_SIZE)
   ) u_fetch (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prod_valid),
      .in_ready  (prod_ready),
      .in_data   (prod_data),
      .out_valid (texel_valid),
      .out_ready (texel_ready),
      .out_data  (texel_data)
   );

   srs_shade u_shade (
      .clock            (clock),
      .reset            (reset),
      .transparent_key  (key_ff),
      .background_color (background_ff),
      .in_valid         (texel_valid),
      .in_ready         (texel_ready),
      .in_data          (texel_data),
      .out_valid        (rsp_valid),
      .out_ready        (rsp_ready),
      .out_data         (rsp_payload)
   );

endmodule

/* hdl/srs_rotate.sv */
module srs_rotate #(
   parameter int unsigned SPRITE_SIZE = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [srs_pkg::ANGLE_W-1:0]   angle_step,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  srs_pkg::req_type              in_data,
   output logic                          out_valid,
   input  logic                          out_ready,
   output srs_pkg::prod_type             out_data
);
   import srs_pkg::*;

   localparam int unsigned HALF = SPRITE_SIZE / 2;

   logic                     s1_valid_ff;
   req_type                  req_ff;
   logic                     s2_valid_ff;
   logic                     s2_valid_in;
   prod_type                 prod_ff;
   prod_type                 prod_in;
   logic [ANGLE_W-1:0]       angle_ff;
   logic [ANGLE_W-1:0]       angle_in;
   logic [ANGLE_W:0]         angle_sum;
   logic                     s1_move;
   logic                     s2_move;
   logic                     tick;
   logic signed [TRIG_W-1:0] cos_val;
   logic signed [TRIG_W-1:0] sin_val;
   logic signed [OFFS_W-1:0] px;
   logic signed [OFFS_W-1:0] py;

   assign s2_move  = !s2_valid_ff || out_ready;
   assign s1_move  = !s1_valid_ff || s2_move;
   assign in_ready = s1_move;
   assign tick     = s1_valid_ff && s2_move && (req_ff.op == OP_TICK);

   always_comb begin
      angle_sum = {1'b0, angle_ff} + {1'b0, angle_step};
      if (angle_sum >= DEG_720) begin
         angle_sum = angle_sum - DEG_720;
      end else if (angle_sum >= DEG_360) begin
         angle_sum = angle_sum - DEG_360;
      end
      angle_in = tick ? ANGLE_W'(angle_sum) : angle_ff;
   end

   always_comb begin
      cos_val = cos_q14(angle_ff);
      sin_val = sin_q14(angle_ff);
      px      = signed'(OFFS_W'(req_ff.dest_x)) - signed'(OFFS_W'(HALF));
      py      = signed'(OFFS_W'(req_ff.dest_y)) - signed'(OFFS_W'(HALF));
      prod_in.op           = req_ff.op;
      prod_in.px_cos       = PROD_W'(px) * PROD_W'(cos_val);
      prod_in.py_sin       = PROD_W'(py) * PROD_W'(sin_val);
      prod_in.py_cos       = PROD_W'(py) * PROD_W'(cos_val);
      prod_in.px_sin       = PROD_W'(px) * PROD_W'(sin_val);
      prod_in.sprite_addr  = req_ff.sprite_addr;
      prod_in.sprite_color = req_ff.sprite_color;
      // ticks end here, and so does an unused op
      s2_valid_in = s1_valid_ff &&
                    ((req_ff.op == OP_LOAD) || (req_ff.op == OP_PIXEL));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         angle_ff    <= '0;
      end else begin
         angle_ff <= angle_in;
         if (s1_move) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_move) begin
            s2_valid_ff <= s2_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move && in_valid) begin
         req_ff <= in_data;
      end
      if (s2_move && s1_valid_ff) begin
         prod_ff <= prod_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = prod_ff;

endmodule

/* hdl/srs_fetch.sv */
module srs_fetch #(
   parameter int unsigned SPRITE_SIZE = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  srs_pkg::prod_type    in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output srs_pkg::texel_type   out_data
);
   import srs_pkg::*;

   localparam int unsigned HALF = SPRITE_SIZE / 2;

   logic [COLOR_W-1:0]      store_mem [0:STORE_DEPTH-1];
   logic                    s3_valid_ff;
   logic [COLOR_W-1:0]      texel_ff;
   logic                    in_range_ff;
   logic                    s3_move;
   logic                    is_load;
   logic                    is_pixel;
   logic signed [SUM_W-1:0] sum_x;
   logic signed [SUM_W-1:0] sum_y;
   logic signed [SRC_W-1:0] src_x;
   logic signed [SRC_W-1:0] src_y;
   logic                    in_range;
   logic [ADDR_W-1:0]       src_addr;

   assign s3_move  = !s3_valid_ff || out_ready;
   assign in_ready = s3_move;
   assign is_load  = in_valid && s3_move && (in_data.op == OP_LOAD);
   assign is_pixel = in_valid && s3_move && (in_data.op == OP_PIXEL);

   // truncate toward zero: bias negative sums before the arithmetic shift
   function automatic logic signed [SRC_W-1:0] trunc_q14(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] biased;
      biased = v + (v[SUM_W-1] ? SUM_W'((1 << FRAC_BITS) - 1) : '0);
      return biased[SUM_W-1:FRAC_BITS];
   endfunction

   always_comb begin
      sum_x    = SUM_W'(in_data.px_cos) + SUM_W'(in_data.py_sin);
      sum_y    = SUM_W'(in_data.py_cos) - SUM_W'(in_data.px_sin);
      src_x    = trunc_q14(sum_x) + signed'(SRC_W'(HALF));
      src_y    = trunc_q14(sum_y) + signed'(SRC_W'(HALF));
      in_range = !src_x[SRC_W-1] && !src_y[SRC_W-1] &&
                 (SRC_W'(src_x) < SRC_W'(SPRITE_SIZE)) &&
                 (SRC_W'(src_y) < SRC_W'(SPRITE_SIZE));
      src_addr = ADDR_W'(ADDR_W'(src_y) * ADDR_W'(SPRITE_SIZE)) + ADDR_W'(src_x);
   end

   always_ff @(posedge clock) begin
      if (is_load) begin
         store_mem[in_data.sprite_addr] <= in_data.sprite_color;
      end
      if (is_pixel) begin
         texel_ff    <= store_mem[src_addr];
         in_range_ff <= in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_move) begin
         s3_valid_ff <= in_valid && (in_data.op == OP_PIXEL);
      end
   end

   assign out_valid         = s3_valid_ff;
   assign out_data.in_range = in_range_ff;
   assign out_data.texel    = texel_ff;

endmodule

/* hdl/srs_shade.sv */
module srs_shade (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [srs_pkg::COLOR_W-1:0]  transparent_key,
   input  logic [srs_pkg::COLOR_W-1:0]  background_color,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  srs_pkg::texel_type           in_data,
   output logic                         out_valid,
   input  logic                         out_ready,
   output srs_pkg::rsp_type             out_data
);
   import srs_pkg::*;

   logic               out_valid_ff;
   rsp_type            out_ff;
   rsp_type            out_in;
   logic               move;
   logic               covered;
   logic [COLOR_W-1:0] color;

   assign move     = !out_valid_ff || out_ready;
   assign in_ready = move;

   always_comb begin
      covered        = in_data.in_range && (in_data.texel != transparent_key);
      color          = covered ? in_data.texel : background_color;
      out_in.red     = {color[15:11], 3'b000};
      out_in.green   = {color[10:5], 2'b00};
      out_in.blue    = {color[4:0], 3'b000};
      out_in.covered = covered;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (move) begin
         out_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (move && in_valid) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule

/* hdl/srs_checker.sv */
module srs_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input srs_pkg::rsp_type             rsp_payload
);
   import srs_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result beat changed while stalled");

   // input backs up only when the output is stalled
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input refused while output free");

   // colour bytes carry only RGB565 bits
   a_low_bits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.red[2:0] == 3'b000) &&
                    (rsp_payload.green[1:0] == 2'b00) &&
                    (rsp_payload.blue[2:0] == 3'b000))
      else $error("colour byte low bits set");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind sprite_rotation_sampler srs_checker u_srs_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

/* verif/tb_sprite_rotation_sampler.sv */
module tb_sprite_rotation_sampler;
   import srs_pkg::*;

   localparam int SPRITE_SIZE = 32;
   localparam int HALF        = SPRITE_SIZE / 2;
   localparam int Q14_ONE     = 16384;
   localparam int STALL_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_COUNT = 6;
   localparam int RANDOM_PER_PHASE = 100;
   localparam op_type        OP_UNUSED  = 2'd3;
   localparam csr_index_type CSR_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_payload;
   logic csr_we = 1'b0;
   csr_index_type csr_index = CSR_ANGLE_STEP;
   logic [COLOR_W-1:0] csr_wdata = '0;

   sprite_rotation_sampler #(.SPRITE_SIZE(SPRITE_SIZE)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // beats waiting to be driven, and pixels expected back
   req_type queued_beats[$];
   rsp_type expected_pixels[$];
   int planned_beats = 0;
   int accepted_beats = 0;
   int phase_items;

   // predictor state, updated on accepted beats and register writes
   logic [COLOR_W-1:0] model_store [0:STORE_DEPTH-1];
   int model_angle, model_step;
   logic [COLOR_W-1:0] model_key, model_bg;

   // planning shadow, used only to keep unwritten texels from being read
   bit gen_written [0:STORE_DEPTH-1];
   int gen_angle = 0;
   int gen_step = ANGLE_STEP_RESET;
   logic [COLOR_W-1:0] gen_key = KEY_RESET;

   bit req_fired = 0, rsp_fired = 0;
   int req_gap = 0, rsp_stall = 0, req_calm = 0, rsp_calm = 0;
   int idle_cycles = 0;
   int mismatches = 0;
   int load_count = 0, tick_count = 0, pixel_count = 0;
   int covered_count = 0, background_count = 0;

   // Q1.14 sine or cosine of k degrees (k <= 45) by Taylor series in Q32
   function automatic int series_q14(int k, bit want_cos);
      longint unsigned x, x2, term, sum, d;
      x = 64'(k) * 64'd74961321;
      x2 = (x * x) >> 32;
      term = want_cos ? 64'h1_0000_0000 : x;
      sum = term;
      for (int n = 1; n <= 7; n++) begin
         d = want_cos ? 64'((2 * n - 1) * (2 * n)) : 64'((2 * n) * (2 * n + 1));
         term = ((term * x2) >> 32) / d;
         if (n % 2 == 1) sum = sum - term;
         else sum = sum + term;
      end
      return int'((sum + 64'h2_0000) >> 18);
   endfunction

   function automatic int quarter_sine(int k);
      if (k <= 45) return series_q14(k, 1'b0);
      return series_q14(90 - k, 1'b1);
   endfunction

   function automatic int sine_deg(int a);
      a = a % 360;
      if (a < 90) return quarter_sine(a);
      if (a < 180) return quarter_sine(180 - a);
      if (a < 270) return -quarter_sine(a - 180);
      return -quarter_sine(360 - a);
   endfunction

   // rotate a destination back to its source texel
   function automatic void map_source(int angle, logic [COORD_W-1:0] dx,
                                      logic [COORD_W-1:0] dy, output int sx, output int sy);
      int c, s, px, py;
      c = sine_deg(angle + 90);
      s = sine_deg(angle);
      px = int'(dx) - HALF;
      py = int'(dy) - HALF;
      sx = (px * c + py * s) / Q14_ONE + HALF;
      sy = (py * c - px * s) / Q14_ONE + HALF;
   endfunction

   function automatic bit in_sprite(int sx, int sy);
      return sx >= 0 && sx < SPRITE_SIZE && sy >= 0 && sy < SPRITE_SIZE;
   endfunction

   task automatic predict_beat(req_type b);
      int sx, sy;
      logic [COLOR_W-1:0] colour;
      rsp_type r;
      case (b.op)
         OP_LOAD: begin
            model_store[b.sprite_addr] = b.sprite_color;
            load_count++;
         end
         OP_TICK: begin
            model_angle = (model_angle + model_step) % 360;
            tick_count++;
         end
         OP_PIXEL: begin
            map_source(model_angle, b.dest_x, b.dest_y, sx, sy);
            colour = model_bg;
            r.covered = 1'b0;
            if (in_sprite(sx, sy)
                && model_store[sy * SPRITE_SIZE + sx] != model_key) begin
               colour = model_store[sy * SPRITE_SIZE + sx];
               r.covered = 1'b1;
            end
            r.red   = {colour[15:11], 3'b000};
            r.green = {colour[10:5], 2'b00};
            r.blue  = {colour[4:0], 3'b000};
            expected_pixels.push_back(r);
            pixel_count++;
         end
         default: ;
      endcase
   endtask

   task automatic check_pixel(rsp_type got);
      rsp_type want;
      if (expected_pixels.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected pixel beat r=%h g=%h b=%h covered=%b",
                     got.red, got.green, got.blue, got.covered);
      end else begin
         want = expected_pixels.pop_front();
         if (got.red !== want.red || got.green !== want.green
             || got.blue !== want.blue || got.covered !== want.covered) begin
            mismatches++;
            if (mismatches <= 10)
               $display("pixel mismatch: expected r=%h g=%h b=%h covered=%b,",
                        want.red, want.green, want.blue, want.covered,
                        " got r=%h g=%h b=%h covered=%b",
                        got.red, got.green, got.blue, got.covered);
         end
         if (want.covered) covered_count++;
         else background_count++;
      end
   endtask

   always @(posedge clock) begin
      req_fired = !reset && req_valid && req_ready;
      rsp_fired = !reset && rsp_valid && rsp_ready;
      if (reset) begin
         model_angle = 0;
         model_step = ANGLE_STEP_RESET;
         model_key = KEY_RESET;
         model_bg = BACKGROUND_RESET;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ANGLE_STEP:      model_step = csr_wdata[ANGLE_W-1:0];
               CSR_TRANSPARENT_KEY: model_key = csr_wdata;
               CSR_BACKGROUND:      model_bg = csr_wdata;
               default: ;
            endcase
         end
         if (req_fired) begin
            predict_beat(req_payload);
            accepted_beats++;
         end
         if (rsp_fired) check_pixel(rsp_payload);
         if ((planned_beats != accepted_beats || expected_pixels.size() != 0)
             && !req_fired && !rsp_fired) begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
               $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
               $display("tb_sprite_rotation_sampler failed");
               $finish;
            end
         end else begin
            idle_cycles = 0;
         end
      end
   end

   // draw a random wait, with occasional stretches of back-to-back beats
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 11);
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fired) begin
         // hold the beat until it is taken
      end else if (req_gap > 0) begin
         req_valid <= 1'b0;
         req_gap--;
      end else if (queued_beats.size() != 0) begin
         req_payload <= queued_beats.pop_front();
         req_valid <= 1'b1;
         req_gap = draw_wait(req_calm);
      end else begin
         req_valid <= 1'b0;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_fired) rsp_stall = draw_wait(rsp_calm);
         if (rsp_stall > 0) begin
            rsp_ready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic req_type random_beat(op_type op);
      req_type b;
      b.op = op;
      b.dest_x = COORD_W'($urandom);
      b.dest_y = COORD_W'($urandom);
      b.sprite_addr = ADDR_W'($urandom);
      b.sprite_color = COLOR_W'($urandom);
      return b;
   endfunction

   function automatic logic [COLOR_W-1:0] pick_colour();
      case ($urandom_range(0, 7))
         0: return gen_key;
         1: return 16'hFFFF;
         2: return 16'h0000;
         default: return COLOR_W'($urandom);
      endcase
   endfunction

   task automatic queue_beat(req_type b);
      queued_beats.push_back(b);
      planned_beats++;
      if (b.op == OP_LOAD) gen_written[b.sprite_addr] = 1'b1;
      if (b.op == OP_TICK) gen_angle = (gen_angle + gen_step) % 360;
      if (b.op != OP_UNUSED) phase_items++;
   endtask

   task automatic queue_load(int addr, logic [COLOR_W-1:0] colour);
      req_type b;
      b = random_beat(OP_LOAD);
      b.sprite_addr = ADDR_W'(addr);
      b.sprite_color = colour;
      queue_beat(b);
   endtask

   // write the source texel first if it has never been loaded
   task automatic queue_pixel(int dx, int dy);
      int sx, sy;
      req_type b;
      map_source(gen_angle, COORD_W'(dx), COORD_W'(dy), sx, sy);
      if (in_sprite(sx, sy) && !gen_written[sy * SPRITE_SIZE + sx])
         queue_load(sy * SPRITE_SIZE + sx, pick_colour());
      b = random_beat(OP_PIXEL);
      b.dest_x = COORD_W'(dx);
      b.dest_y = COORD_W'(dy);
      queue_beat(b);
   endtask

   task automatic write_reg(csr_index_type idx, logic [COLOR_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_ANGLE_STEP) gen_step = int'(value[ANGLE_W-1:0]);
      if (idx == CSR_TRANSPARENT_KEY) gen_key = value;
      @(negedge clock);
   endtask

   task automatic configure(int phase);
      case (phase)
         1: begin
            write_reg(CSR_ANGLE_STEP, 16'd42);
            write_reg(CSR_TRANSPARENT_KEY, 16'h0000);
            write_reg(CSR_BACKGROUND, 16'hFFFF);
         end
         2: begin
            write_reg(CSR_ANGLE_STEP, 16'd359);
            write_reg(CSR_TRANSPARENT_KEY, COLOR_W'($urandom));
            write_reg(CSR_BACKGROUND, COLOR_W'($urandom));
            write_reg(CSR_UNUSED, COLOR_W'($urandom));
         end
         3: begin
            // upper bits of the step write must be dropped
            write_reg(CSR_ANGLE_STEP, 16'hFFFF);
            write_reg(CSR_TRANSPARENT_KEY, 16'hFFFF);
            write_reg(CSR_BACKGROUND, 16'h0000);
         end
         4: begin
            write_reg(CSR_ANGLE_STEP, 16'd0);
            write_reg(CSR_TRANSPARENT_KEY, COLOR_W'($urandom));
            write_reg(CSR_BACKGROUND, 16'hF81F);
         end
         default: begin
            write_reg(CSR_ANGLE_STEP, 16'd90);
            write_reg(CSR_TRANSPARENT_KEY, 16'h07E0);
            write_reg(CSR_BACKGROUND, 16'h001F);
         end
      endcase
      csr_we <= 1'b0;
   endtask

   task automatic random_run(int count);
      int pick, cx, cy;
      phase_items = 0;
      while (phase_items < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            queue_pixel($urandom_range(0, 31), $urandom_range(0, 31));
         end else if (pick < 70) begin
            queue_load($urandom_range(0, STORE_DEPTH - 1), pick_colour());
         end else if (pick < 82) begin
            queue_beat(random_beat(OP_TICK));
         end else if (pick < 86) begin
            queue_beat(random_beat(OP_UNUSED));
         end else begin
            // advance, then sample a small cluster near the centre
            queue_beat(random_beat(OP_TICK));
            cx = $urandom_range(8, 23);
            cy = $urandom_range(8, 23);
            queue_pixel(cx, cy);
            queue_pixel(cx + 1, cy);
            queue_pixel(cx, cy + 1);
         end
      end
   endtask

   task automatic settle();
      while (planned_beats != accepted_beats || expected_pixels.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase > 0) configure(phase);
         if (phase == 0) begin
            queue_load(0, 16'hFFFF);
            queue_load(STORE_DEPTH - 1, 16'hF800);
            queue_load(HALF * SPRITE_SIZE + HALF, 16'h07E0);
            queue_load(SPRITE_SIZE + 1, 16'h001F);
            queue_load(1, 16'h0000);
            queue_pixel(0, 0);
            queue_pixel(31, 31);
            queue_pixel(HALF, HALF);
            queue_pixel(1, 1);
            queue_pixel(1, 0);
            queue_beat(random_beat(OP_UNUSED));
            queue_beat(random_beat(OP_TICK));
            queue_pixel(0, 0);
            queue_pixel(31, 0);
            queue_pixel(0, 31);
            queue_pixel(31, 31);
         end else if (phase == 1) begin
            // advance by the new step, then sample the corners and the centre
            queue_beat(random_beat(OP_TICK));
            queue_pixel(0, 0);
            queue_pixel(31, 31);
            queue_pixel(0, 31);
            queue_pixel(31, 0);
            queue_pixel(HALF, HALF);
         end
         random_run(RANDOM_PER_PHASE);
         settle();
      end
      $display("%0d beats over %0d register settings: %0d loads, %0d ticks, %0d pixels",
               accepted_beats, PHASE_COUNT, load_count, tick_count, pixel_count);
      $display("pixels from sprite texels: %0d, from background: %0d, mismatches: %0d",
               covered_count, background_count, mismatches);
      if (mismatches == 0) begin
         $display("tb_sprite_rotation_sampler passed");
      end else begin
         $display("tb_sprite_rotation_sampler failed");
      end
      $finish;
   end

endmodule
